/* rtl/core/pidsc_pkg.sv */
// Package for the PID speed controller core.
// Holds the register map, reset values, configuration struct and stage beat type.
// No dependencies.
package pidsc_pkg;

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_MAX_OUT   = 3'd3,
        REG_INTEG_LIM = 3'd4,
        REG_DEADBAND  = 3'd5,
        REG_I_SPLIT   = 3'd6
    } t_reg_idx;

    localparam logic [15:0] KP_RST        = 16'd3072;
    localparam logic [15:0] KI_RST        = 16'd26;
    localparam logic [15:0] KD_RST        = 16'd2560;
    localparam logic [14:0] MAX_OUT_RST   = 15'd800;
    localparam logic [14:0] INTEG_LIM_RST = 15'd10;
    localparam logic [15:0] DEADBAND_RST  = 16'd10;
    localparam logic [15:0] I_SPLIT_RST   = 16'd0;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [14:0] max_out;
        logic [14:0] integ_lim;
        logic [15:0] deadband;
        logic [15:0] i_split;
    } t_cfg;

    typedef struct packed {
        logic               clr;
        logic signed [16:0] err;
    } t_err_beat;

endpackage

/* rtl/core/pidsc_if.sv */
// Valid/ready channel interfaces for the PID speed controller core.
// Input channel carries one command beat, output channel one drive beat.
interface pidsc_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] target;
    logic signed [15:0] measured;

    modport source (output valid, cmd, target, measured, input ready);
    modport sink   (input valid, cmd, target, measured, output ready);
endinterface

interface pidsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

/* rtl/core/pidsc_regs.sv */
// APB configuration register file of the PID speed controller core.
// Depends on pidsc_pkg for the register map and reset values.
module pidsc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidsc_pkg::PADDR_W-1:0] paddr,
    input  logic [pidsc_pkg::APB_DW-1:0]  pwdata,
    output logic [pidsc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output pidsc_pkg::t_cfg              o_cfg
);
    import pidsc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp        <= KP_RST;
            r_cfg.ki        <= KI_RST;
            r_cfg.kd        <= KD_RST;
            r_cfg.max_out   <= MAX_OUT_RST;
            r_cfg.integ_lim <= INTEG_LIM_RST;
            r_cfg.deadband  <= DEADBAND_RST;
            r_cfg.i_split   <= I_SPLIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_KP:        r_cfg.kp        <= pwdata[15:0];
                REG_KI:        r_cfg.ki        <= pwdata[15:0];
                REG_KD:        r_cfg.kd        <= pwdata[15:0];
                REG_MAX_OUT:   r_cfg.max_out   <= pwdata[14:0];
                REG_INTEG_LIM: r_cfg.integ_lim <= pwdata[14:0];
                REG_DEADBAND:  r_cfg.deadband  <= pwdata[15:0];
                REG_I_SPLIT:   r_cfg.i_split   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KP:        prdata = {16'd0, r_cfg.kp};
            REG_KI:        prdata = {16'd0, r_cfg.ki};
            REG_KD:        prdata = {16'd0, r_cfg.kd};
            REG_MAX_OUT:   prdata = {17'd0, r_cfg.max_out};
            REG_INTEG_LIM: prdata = {17'd0, r_cfg.integ_lim};
            REG_DEADBAND:  prdata = {16'd0, r_cfg.deadband};
            REG_I_SPLIT:   prdata = {16'd0, r_cfg.i_split};
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/core/pidsc_err.sv */
// Input stage of the PID speed controller core: forms the deadbanded error.
// Depends on pidsc_pkg and the pidsc_in_if channel interface.
module pidsc_err (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pidsc_pkg::t_cfg      i_cfg,
    pidsc_in_if.sink             i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pidsc_pkg::t_err_beat o_beat
);
    import pidsc_pkg::*;

    logic               r_valid;
    t_err_beat          r_beat;
    t_err_beat          n_beat;
    logic signed [16:0] w_err;
    logic signed [17:0] w_err_x;
    logic signed [17:0] w_db;
    logic               w_dead;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_beat     = r_beat;

    always_comb begin
        w_err   = $signed({i_in.target[15], i_in.target})
                - $signed({i_in.measured[15], i_in.measured});
        w_err_x = $signed({w_err[16], w_err});
        w_db    = $signed({2'b00, i_cfg.deadband});
        w_dead  = (w_err_x > -w_db) && (w_err_x < w_db);
        n_beat.clr = i_in.cmd;
        n_beat.err = w_dead ? 17'sd0 : w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_beat <= n_beat;
        end
    end

endmodule

/* rtl/core/pidsc_law.sv */
// Control law stage of the PID speed controller core: P, I and D terms, the
// integrator and error history, and the output result register.
// Depends on pidsc_pkg and the pidsc_out_if channel interface.
module pidsc_law (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pidsc_pkg::t_cfg      i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pidsc_pkg::t_err_beat i_beat,
    pidsc_out_if.source          o_out
);
    import pidsc_pkg::*;

    logic               r_out_valid;
    logic signed [15:0] r_drive;
    logic signed [16:0] r_prev_err;
    logic signed [23:0] r_acc;

    logic signed [15:0] n_drive;
    logic signed [16:0] n_prev_err;
    logic signed [23:0] n_acc;

    logic               w_take;
    logic signed [16:0] w_e;
    logic signed [17:0] w_e_x;
    logic signed [33:0] w_pprod;
    logic signed [25:0] w_pfl;
    logic signed [25:0] w_plim;
    logic signed [15:0] w_p;
    logic signed [33:0] w_iprod;
    logic signed [34:0] w_acc_sum;
    logic signed [34:0] w_ilim;
    logic signed [23:0] w_acc_new;
    logic signed [17:0] w_de;
    logic signed [34:0] w_dprod;
    logic signed [26:0] w_dfl;
    logic signed [17:0] w_split;
    logic               w_frozen;
    logic signed [15:0] w_iterm;
    logic signed [28:0] w_sum;
    logic signed [28:0] w_slim;
    logic signed [15:0] w_sum_c;

    assign o_ready     = !r_out_valid || o_out.ready;
    assign w_take      = i_valid && o_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;

    always_comb begin
        w_e    = i_beat.err;
        w_e_x  = $signed({w_e[16], w_e});

        w_pprod = 34'($signed({1'b0, i_cfg.kp})) * 34'(w_e);
        w_pfl   = w_pprod[33:8];
        w_plim  = $signed({11'd0, i_cfg.max_out});
        if (w_pfl > w_plim) begin
            w_p = w_plim[15:0];
        end else if (w_pfl < -w_plim) begin
            w_p = 16'(-w_plim);
        end else begin
            w_p = w_pfl[15:0];
        end

        w_iprod   = 34'($signed({1'b0, i_cfg.ki})) * 34'(w_e);
        w_acc_sum = $signed({{11{r_acc[23]}}, r_acc}) + $signed({w_iprod[33], w_iprod});
        w_ilim    = $signed({12'd0, i_cfg.integ_lim, 8'd0});
        if (w_acc_sum > w_ilim) begin
            w_acc_new = w_ilim[23:0];
        end else if (w_acc_sum < -w_ilim) begin
            w_acc_new = 24'(-w_ilim);
        end else begin
            w_acc_new = w_acc_sum[23:0];
        end

        w_de    = w_e_x - $signed({r_prev_err[16], r_prev_err});
        w_dprod = 35'($signed({1'b0, i_cfg.kd})) * 35'(w_de);
        w_dfl   = w_dprod[34:8];

        w_split  = $signed({2'b00, i_cfg.i_split});
        w_frozen = (w_e_x > -w_split) && (w_e_x < w_split);
        w_iterm  = w_frozen ? 16'sd0 : w_acc_new[23:8];

        w_sum  = $signed({{13{w_p[15]}}, w_p})
               + $signed({{13{w_iterm[15]}}, w_iterm})
               + $signed({{2{w_dfl[26]}}, w_dfl});
        w_slim = $signed({14'd0, i_cfg.max_out});
        if (w_sum > w_slim) begin
            w_sum_c = w_slim[15:0];
        end else if (w_sum < -w_slim) begin
            w_sum_c = 16'(-w_slim);
        end else begin
            w_sum_c = w_sum[15:0];
        end

        if (i_beat.clr) begin
            n_drive    = 16'sd0;
            n_prev_err = 17'sd0;
            n_acc      = 24'sd0;
        end else begin
            n_drive    = w_sum_c;
            n_prev_err = w_e;
            n_acc      = w_frozen ? r_acc : w_acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_err  <= 17'sd0;
            r_acc       <= 24'sd0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
            r_prev_err  <= n_prev_err;
            r_acc       <= n_acc;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_drive <= n_drive;
        end
    end

endmodule

/* rtl/core/pid_speed_controller_core.sv */
// Top level of the PID speed controller core.
// Depends on pidsc_pkg, pidsc_if, pidsc_regs, pidsc_err and pidsc_law.
//
// Positional PID step in fixed point, one beat per clock cycle while the
// output channel is not stalled. A beat accepted on the input channel is
// registered as a deadbanded error; once the control-law stage can take it,
// the control law computes P, I and D, updates the integrator and error
// history and loads the drive result register. The error register and the
// result register lie around the single control-law stage, whose state
// feedback closes within the stage, so back-to-back beats are taken without
// gaps. A cmd of one clears the integrator and error history and returns a
// drive of zero. Configure only while no beat is in flight.
module pid_speed_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidsc_pkg::PADDR_W-1:0] paddr,
    input  logic [pidsc_pkg::APB_DW-1:0]  pwdata,
    output logic [pidsc_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    pidsc_in_if.sink                      i_in,
    pidsc_out_if.source                   o_out
);
    import pidsc_pkg::*;

    t_cfg      w_cfg;
    logic      w_err_valid;
    logic      w_law_ready;
    t_err_beat w_err_beat;

    pidsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidsc_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_valid (w_err_valid),
        .i_ready (w_law_ready),
        .o_beat  (w_err_beat)
    );

    pidsc_law u_law (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_err_valid),
        .o_ready (w_law_ready),
        .i_beat  (w_err_beat),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/pidsc_checker.sv */
// Port-level checker for the PID speed controller core and its bind.
// Depends on the top level pid_speed_controller_core.
module pidsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_out_drive
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Result beat offered right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_drive))
        else $error("Stalled result beat changed or vanished.");

    a_drive_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_drive != 16'sh8000)
        else $error("Drive left the symmetric clamp range.");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("Configuration port inserted a wait state.");

endmodule

bind pid_speed_controller_core pidsc_checker u_pidsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pready    (pready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_drive (o_out.drive)
);
